FILE: sv/rba_pkg.sv
`default_nettype none

package rba_pkg;

   // fixed field widths
   localparam int ADDR_W = 21;
   localparam int ACT_W  = 2;
   localparam int STAT_W = 2;

   // default sizing
   localparam int DEF_POOL_BYTES  = 1048576;
   localparam int DEF_MAX_REGIONS = 32;

   // action codes
   localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RESIZE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_EXEC
   } state_type;

   // broadcast command to every cell
   typedef struct packed {
      logic              shift;
      logic              load;
      logic              trim;
      logic [ADDR_W-1:0] new_start;
      logic [ADDR_W-1:0] new_len;
   } cell_cmd_type;

   // running sums handed from cell to cell
   typedef struct packed {
      logic              hit;
      logic [ADDR_W:0]   tail_end;
      logic [ADDR_W-1:0] sel_start;
      logic [ADDR_W-1:0] sel_len;
   } cell_sum_type;

endpackage

`default_nettype wire

FILE: sv/rba_cell.sv
`default_nettype none

module rba_cell
   import rba_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 6
) (
   input  wire logic              clock,
   input  wire logic [CNT_W-1:0]  count_in,
   input  wire logic [ADDR_W-1:0] addr_in,
   input  wire logic              scan_en,
   input  wire cell_cmd_type      cmd,
   input  wire logic [CNT_W-1:0]  load_idx,
   input  wire logic [ADDR_W-1:0] nbr_start_in,
   input  wire logic [ADDR_W-1:0] nbr_len_in,
   output logic      [ADDR_W-1:0] start_out,
   output logic      [ADDR_W-1:0] len_out,
   input  wire cell_sum_type      sum_in,
   output cell_sum_type           sum_out
);

   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] len_ff, len_in;
   logic              sel_ff, sel_in;
   logic              past_ff, past_in;
   logic              live, last, match;

   assign live  = CNT_W'(INDEX) < count_in;
   assign last  = CNT_W'(INDEX + 1) == count_in;
   assign match = live && (start_ff == addr_in);

   always_comb begin
      sum_out.hit       = sum_in.hit | match;
      sum_out.tail_end  = sum_in.tail_end
                        | (last ? ({1'b0, start_ff} + {1'b0, len_ff}) : '0);
      sum_out.sel_start = sum_in.sel_start | (sel_ff ? start_ff : '0);
      sum_out.sel_len   = sum_in.sel_len | (sel_ff ? len_ff : '0);
   end

   assign start_out = start_ff;
   assign len_out   = len_ff;

   always_comb begin
      sel_in  = sel_ff;
      past_in = past_ff;
      if (scan_en) begin
         sel_in  = match & ~sum_in.hit;
         past_in = sum_out.hit;
      end
   end

   // load wins over shift so a moved block lands in the freed tail slot
   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      if (cmd.load && (load_idx == CNT_W'(INDEX))) begin
         start_in = cmd.new_start;
         len_in   = cmd.new_len;
      end else if (cmd.shift && past_ff) begin
         start_in = nbr_start_in;
         len_in   = nbr_len_in;
      end else if (cmd.trim && sel_ff) begin
         len_in = cmd.new_len;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
      sel_ff   <= sel_in;
      past_ff  <= past_in;
   end

endmodule

`default_nettype wire

FILE: sv/rba_chain.sv
`default_nettype none

module rba_chain
   import rba_pkg::*;
#(
   parameter int MAX_REGIONS = DEF_MAX_REGIONS,
   parameter int CNT_W       = $clog2(DEF_MAX_REGIONS + 1)
) (
   input  wire logic              clock,
   input  wire logic [CNT_W-1:0]  count_in,
   input  wire logic [ADDR_W-1:0] addr_in,
   input  wire logic              scan_en,
   input  wire cell_cmd_type      cmd,
   input  wire logic [CNT_W-1:0]  load_idx,
   output cell_sum_type           sum_out
);

   cell_sum_type      sums [0:MAX_REGIONS];
   logic [ADDR_W-1:0] starts [0:MAX_REGIONS];
   logic [ADDR_W-1:0] lens [0:MAX_REGIONS];

   assign sums[0]             = '0;
   assign starts[MAX_REGIONS] = '0;
   assign lens[MAX_REGIONS]   = '0;

   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      rba_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock        (clock),
         .count_in     (count_in),
         .addr_in      (addr_in),
         .scan_en      (scan_en),
         .cmd          (cmd),
         .load_idx     (load_idx),
         .nbr_start_in (starts[i+1]),
         .nbr_len_in   (lens[i+1]),
         .start_out    (starts[i]),
         .len_out      (lens[i]),
         .sum_in       (sums[i]),
         .sum_out      (sums[i+1])
      );
   end

   assign sum_out = sums[MAX_REGIONS];

endmodule

`default_nettype wire

FILE: sv/region_bump_allocator_core.sv
// a request is registered when accepted, then the scan and pick passes over the cell row register
// their results and the execute pass loads the response register; no new request is accepted until
// that pass fires, and a stalled response holds the execute pass until it leaves
// only one request is in flight; a finished response waits in the output register
// reset (synchronous, active high) empties the table and drops any pending response
// table contents are undefined until written and get no clearing pass
`default_nettype none

module region_bump_allocator_core
   import rba_pkg::*;
#(
   parameter int POOL_BYTES  = DEF_POOL_BYTES,
   parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [ACT_W-1:0]  req_action,
   input  wire logic [ADDR_W-1:0] req_block_address,
   input  wire logic [ADDR_W-1:0] req_request_size,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [STAT_W-1:0] rsp_status,
   output logic      [ADDR_W-1:0] rsp_result_address,
   output logic      [ADDR_W-1:0] rsp_copy_source,
   output logic      [ADDR_W-1:0] rsp_copy_length
);

   localparam int CNT_W = $clog2(MAX_REGIONS + 1);

   // control state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // request held for the duration of the operation
   logic [ACT_W-1:0]  action_ff, action_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] size_ff, size_in;

   // results of the scan and pick passes
   logic [ADDR_W:0]   base_ff, base_in;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] old_start_ff, old_start_in;
   logic [ADDR_W-1:0] old_len_ff, old_len_in;

   // response register
   logic [STAT_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0] res_ff, res_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [ADDR_W-1:0] len_ff, len_in;

   logic              accept;
   logic              room;
   logic              fire;
   logic              exhausted;
   logic              full;
   logic              grow;
   logic [31:0]       span;
   cell_cmd_type      cmd;
   logic [CNT_W-1:0]  load_idx;
   cell_sum_type      sum;

   // decision of the execute pass, before it is gated by fire
   logic [STAT_W-1:0] d_status;
   logic [ADDR_W-1:0] d_res, d_src, d_len;
   logic [CNT_W-1:0]  d_count;
   cell_cmd_type      d_cmd;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign room      = !rsp_valid_ff || !rsp_stall;
   assign fire      = (state_ff == ST_EXEC) && room;

   // the cell row: compare, first-match chain, tail end and compaction
   rba_chain #(
      .MAX_REGIONS (MAX_REGIONS),
      .CNT_W       (CNT_W)
   ) u_chain (
      .clock    (clock),
      .count_in (count_ff),
      .addr_in  (addr_ff),
      .scan_en  (state_ff == ST_SCAN),
      .cmd      (cmd),
      .load_idx (load_idx),
      .sum_out  (sum)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: state_in = ST_PICK;
         ST_PICK: state_in = ST_EXEC;
         ST_EXEC: begin
            if (room) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // pool and table checks, shared by allocate and a growing resize
   assign span      = {{(31 - ADDR_W){1'b0}}, base_ff} + {{(32 - ADDR_W){1'b0}}, size_ff};
   assign exhausted = span > 32'(POOL_BYTES);
   assign full      = count_ff == CNT_W'(MAX_REGIONS);
   assign grow      = old_len_ff < size_ff;

   // what the execute pass would do
   always_comb begin
      d_status      = STAT_OK;
      d_res         = '0;
      d_src         = '0;
      d_len         = '0;
      d_count       = count_ff;
      d_cmd         = '0;
      d_cmd.new_start = base_ff[ADDR_W-1:0];
      d_cmd.new_len   = size_ff;
      load_idx      = count_ff;
      case (action_ff)
         ACT_ALLOC: begin
            if (exhausted) begin
               d_status = STAT_EXHAUSTED;
            end else if (full) begin
               d_status = STAT_FULL;
            end else begin
               d_cmd.load = 1'b1;
               d_res      = base_ff[ADDR_W-1:0];
               d_count    = count_ff + 1'b1;
            end
         end
         ACT_RESIZE: begin
            if (!found_ff) begin
               d_status = STAT_NOT_FOUND;
            end else if (!grow) begin
               // shrink in place
               d_cmd.trim = 1'b1;
               d_res      = old_start_ff;
            end else if (exhausted) begin
               d_status = STAT_EXHAUSTED;
            end else if (full) begin
               d_status = STAT_FULL;
            end else begin
               // close the gap and append at what becomes the tail slot
               d_cmd.shift = 1'b1;
               d_cmd.load  = 1'b1;
               load_idx    = count_ff - 1'b1;
               d_res       = base_ff[ADDR_W-1:0];
               d_src       = old_start_ff;
               d_len       = old_len_ff;
            end
         end
         ACT_RELEASE: begin
            if (!found_ff) begin
               d_status = STAT_NOT_FOUND;
            end else begin
               d_cmd.shift = 1'b1;
               d_count     = count_ff - 1'b1;
            end
         end
         default: begin
            // unused action code: no change, all-zero ok response
            d_status = STAT_OK;
         end
      endcase
   end

   // outputs of the state machine
   always_comb begin
      cmd          = '0;
      count_in     = count_ff;
      status_in    = status_ff;
      res_in       = res_ff;
      src_in       = src_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      action_in    = action_ff;
      addr_in      = addr_ff;
      size_in      = size_ff;
      base_in      = base_ff;
      found_in     = found_ff;
      old_start_in = old_start_ff;
      old_len_in   = old_len_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               action_in = req_action;
               addr_in   = req_block_address;
               size_in   = req_request_size;
            end
         end
         ST_SCAN: begin
            base_in  = sum.tail_end;
            found_in = sum.hit;
         end
         ST_PICK: begin
            old_start_in = sum.sel_start;
            old_len_in   = sum.sel_len;
         end
         ST_EXEC: begin
            if (fire) begin
               cmd          = d_cmd;
               count_in     = d_count;
               status_in    = d_status;
               res_in       = d_res;
               src_in       = d_src;
               len_in       = d_len;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      addr_ff      <= addr_in;
      size_ff      <= size_in;
      base_ff      <= base_in;
      found_ff     <= found_in;
      old_start_ff <= old_start_in;
      old_len_ff   <= old_len_in;
      status_ff    <= status_in;
      res_ff       <= res_in;
      src_ff       <= src_in;
      len_ff       <= len_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_result_address = res_ff;
   assign rsp_copy_source    = src_ff;
   assign rsp_copy_length    = len_ff;

endmodule

`default_nettype wire
